// ===== src/cpd_pkg.sv =====
// cpd_pkg: shared types, constants and the crc-16 byte update for the packet deframer
// no dependencies; imported by every module under src

package cpd_pkg;

    localparam int LENGTH_FIELD_BYTES_DEF = 4;
    localparam int IDX_W                  = 32;
    localparam int SYNC_BYTES             = 2;
    localparam int HEADER_TAIL_BYTES      = 3;
    localparam int MIN_LENGTH             = 5;
    localparam int CFG_IDX_W              = 1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_SYNC  = 3'd2,
        ST_CRC   = 3'd3,
        ST_LEN   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       verdict_valid;
        status_t    status;
        logic [7:0] frame_id;
        logic [7:0] frame_type;
        logic [7:0] frame_module;
    } result_t;

    // msb-first crc-16, one byte, no reflection
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          i;
        c = crc ^ {b, 8'h00};
        for (i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== src/cpd_parser.sv =====
// cpd_parser: input register and frame parsing state, one byte per cycle while the output buffer has room
// depends on cpd_pkg

module cpd_parser #(
    parameter int LENGTH_FIELD_BYTES = cpd_pkg::LENGTH_FIELD_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             last_of_buffer,
    input  logic [7:0]       sync_first,
    input  logic [7:0]       sync_second,
    input  logic             room,
    output logic             push,
    output cpd_pkg::result_t result
);
    import cpd_pkg::*;

    localparam int LEN_W   = 8 * LENGTH_FIELD_BYTES;
    localparam int CMP_W   = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 2;
    localparam int POS_LEN = SYNC_BYTES;
    localparam int POS_ID  = SYNC_BYTES + LENGTH_FIELD_BYTES;
    localparam int POS_TYP = POS_ID + 1;
    localparam int POS_MOD = POS_ID + 2;

    logic              s1_valid_reg, s1_valid_next;
    logic [7:0]        s1_data_reg;
    logic              s1_last_reg;
    logic              accept;
    logic              advance;

    logic [IDX_W-1:0]  byte_index_reg, byte_index_next;
    logic [LEN_W-1:0]  declared_length_reg, declared_length_next;
    logic [15:0]       running_crc_reg, running_crc_next;
    logic [7:0]        crc_low_reg, crc_low_next;
    logic [7:0]        held_id_reg, held_id_next;
    logic [7:0]        held_type_reg, held_type_next;
    logic [7:0]        held_module_reg, held_module_next;
    logic              sync_bad_reg, sync_bad_next;
    logic              verdict_given_reg, verdict_given_next;

    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  body_end;
    logic [7:0]        id_now, type_now, module_now;
    logic              pay, verd;
    status_t           st;

    assign accept   = in_valid && !in_stall;
    assign advance  = s1_valid_reg && room;
    assign in_stall = s1_valid_reg && !room;

    assign idx_ext  = CMP_W'(byte_index_reg);
    assign body_end = CMP_W'(LENGTH_FIELD_BYTES) + CMP_W'(declared_length_reg);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        declared_length_next = declared_length_reg;
        running_crc_next     = running_crc_reg;
        crc_low_next         = crc_low_reg;
        sync_bad_next        = sync_bad_reg;
        id_now               = held_id_reg;
        type_now             = held_type_reg;
        module_now           = held_module_reg;
        pay                  = 1'b0;
        verd                 = 1'b0;
        st                   = ST_OK;

        if (!verdict_given_reg)
        begin
            if (byte_index_reg == IDX_W'(0))
            begin
                if (s1_data_reg != sync_first)
                begin
                    sync_bad_next = 1'b1;
                end
            end
            else if (byte_index_reg == IDX_W'(1))
            begin
                if (s1_data_reg != sync_second)
                begin
                    sync_bad_next = 1'b1;
                end
            end
            else if (byte_index_reg < IDX_W'(POS_ID))
            begin
                for (int k = 0; k < LENGTH_FIELD_BYTES; k++)
                begin
                    if (byte_index_reg == IDX_W'(POS_LEN + k))
                    begin
                        declared_length_next[8*k +: 8] = s1_data_reg;
                    end
                end
            end
            else
            begin
                if (byte_index_reg == IDX_W'(POS_ID))
                begin
                    id_now = s1_data_reg;
                end
                if (byte_index_reg == IDX_W'(POS_TYP))
                begin
                    type_now = s1_data_reg;
                end
                if (byte_index_reg == IDX_W'(POS_MOD))
                begin
                    module_now = s1_data_reg;
                end

                if (idx_ext < body_end)
                begin
                    running_crc_next = crc16_byte(running_crc_reg, s1_data_reg);
                end

                if (byte_index_reg == IDX_W'(POS_MOD))
                begin
                    if (sync_bad_reg)
                    begin
                        verd = 1'b1;
                        st   = ST_SYNC;
                    end
                    else if (declared_length_reg < LEN_W'(MIN_LENGTH))
                    begin
                        verd = 1'b1;
                        st   = ST_LEN;
                    end
                end
                else if (byte_index_reg > IDX_W'(POS_MOD))
                begin
                    if (idx_ext < body_end)
                    begin
                        pay = 1'b1;
                    end
                    else if (idx_ext == body_end)
                    begin
                        crc_low_next = s1_data_reg;
                    end
                    else if (idx_ext == body_end + CMP_W'(1))
                    begin
                        verd = 1'b1;
                        st   = ({s1_data_reg, crc_low_reg} == running_crc_reg) ? ST_OK : ST_CRC;
                    end
                end
            end

            if (!verd && s1_last_reg)
            begin
                verd = 1'b1;
                st   = ST_SHORT;
                pay  = 1'b0;
            end
        end

        if (s1_last_reg)
        begin
            declared_length_next = '0;
            running_crc_next     = CRC_INIT;
            crc_low_next         = '0;
            sync_bad_next        = 1'b0;
        end
    end

    always_comb
    begin
        byte_index_next    = (byte_index_reg != '1) ? byte_index_reg + IDX_W'(1) : byte_index_reg;
        verdict_given_next = verdict_given_reg || verd;
        held_id_next       = id_now;
        held_type_next     = type_now;
        held_module_next   = module_now;
        if (s1_last_reg)
        begin
            byte_index_next    = '0;
            held_id_next       = '0;
            held_type_next     = '0;
            held_module_next   = '0;
            verdict_given_next = 1'b0;
        end
    end

    always_comb
    begin
        push                 = advance && (pay || verd);
        result.payload_byte  = pay ? s1_data_reg : 8'h00;
        result.payload_valid = pay && !verd;
        result.verdict_valid = verd;
        result.status        = verd ? st : ST_OK;
        result.frame_id      = verd ? id_now : 8'h00;
        result.frame_type    = verd ? type_now : 8'h00;
        result.frame_module  = verd ? module_now : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_of_buffer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg      <= '0;
            declared_length_reg <= '0;
            running_crc_reg     <= CRC_INIT;
            crc_low_reg         <= '0;
            held_id_reg         <= '0;
            held_type_reg       <= '0;
            held_module_reg     <= '0;
            sync_bad_reg        <= 1'b0;
            verdict_given_reg   <= 1'b0;
        end
        else if (advance)
        begin
            byte_index_reg      <= byte_index_next;
            declared_length_reg <= declared_length_next;
            running_crc_reg     <= running_crc_next;
            crc_low_reg         <= crc_low_next;
            held_id_reg         <= held_id_next;
            held_type_reg       <= held_type_next;
            held_module_reg     <= held_module_next;
            sync_bad_reg        <= sync_bad_next;
            verdict_given_reg   <= verdict_given_next;
        end
    end

`ifndef SYNTHESIS
    a_silent_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && verdict_given_reg) |-> !push)
        else $error("result produced after verdict");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> $onehot({result.payload_valid, result.verdict_valid}))
        else $error("result is neither or both payload and verdict");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_last_reg) |=> (byte_index_reg == '0) && !verdict_given_reg)
        else $error("parser not restarted after end of buffer");
`endif

endmodule

// ===== src/cpd_out_buf.sv =====
// cpd_out_buf: two-entry result register with skid slot toward the output channel
// depends on cpd_pkg

module cpd_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cpd_pkg::result_t result,
    output logic             room,
    output logic             out_valid,
    input  logic             out_stall,
    output cpd_pkg::result_t out_result
);
    import cpd_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop        = main_valid_reg && !out_stall;
    assign room       = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_result = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_next = push;
            main_next       = result;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid slot holds a result while output register is empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into full buffer");
`endif

endmodule

// ===== src/crc16_packet_deframer.sv =====
// crc16_packet_deframer: top level, holds the two sync registers and joins cpd_parser
// to cpd_out_buf; depends on cpd_pkg. one received byte is taken per clock
// cycle for as long as results are taken; a byte passes the input register, and
// its result is then held in the output buffer's result register. the rate
// is set by the 8-bit unrolled crc-16 update that sits behind the input register.
// results queue in a two-entry output buffer, so input stalls only once two
// results wait unread. sync values are written over the cfg channel, which is
// always ready; write them only while no bytes are in flight.

module crc16_packet_deframer #(
    parameter int LENGTH_FIELD_BYTES = cpd_pkg::LENGTH_FIELD_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          last_of_buffer,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    payload_byte,
    output logic                          payload_valid,
    output logic                          verdict_valid,
    output logic [2:0]                    status,
    output logic [7:0]                    frame_id,
    output logic [7:0]                    frame_type,
    output logic [7:0]                    frame_module,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import cpd_pkg::*;

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic       room;
    logic       push;
    result_t    result;
    result_t    out_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SYNC_FIRST:
                begin
                    sync_first_reg <= cfg_data;
                end
                REG_SYNC_SECOND:
                begin
                    sync_second_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    cpd_parser #(
        .LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_of_buffer (last_of_buffer),
        .sync_first     (sync_first_reg),
        .sync_second    (sync_second_reg),
        .room           (room),
        .push           (push),
        .result         (result)
    );

    cpd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .result     (result),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign payload_byte  = out_result.payload_byte;
    assign payload_valid = out_result.payload_valid;
    assign verdict_valid = out_result.verdict_valid;
    assign status        = out_result.status;
    assign frame_id      = out_result.frame_id;
    assign frame_type    = out_result.frame_type;
    assign frame_module  = out_result.frame_module;

endmodule
